// File: hw/rtl/spam_pkg.sv
`timescale 1ns / 1ps

package spam_pkg;

  localparam int MAX_TERMS_DEF = 32;

  localparam int DEG_W  = 6;
  localparam int COEF_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 37;
  localparam int ST_W   = 2;

  localparam logic [2:0] OP_LOAD_A = 3'd0;
  localparam logic [2:0] OP_LOAD_B = 3'd1;
  localparam logic [2:0] OP_SUM    = 3'd2;
  localparam logic [2:0] OP_PROD   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic start;
    logic hit;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
    logic present;
  } mac_stat_t;

endpackage

// File: hw/rtl/spam_mac.sv
`timescale 1ns / 1ps

module spam_mac import spam_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [COEF_W-1:0] b,
  output mac_stat_t                stat,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     hit2;
  logic                     last2;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit2  <= 1'b0;
      last2 <= 1'b0;
      stat  <= '0;
    end else begin
      hit2      <= ctl.hit;
      last2     <= ctl.last;
      stat.done <= last2;
      if (ctl.start) begin
        stat.present <= 1'b0;
      end else if (hit2) begin
        stat.present <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= '0;
    end else if (hit2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// File: hw/rtl/sparse_polynomial_add_multiply_unit.sv
`timescale 1ns / 1ps
// Channel  Handshake            Beat
// input    in_valid / in_stall  opcode, degree, coefficient
// output   out_valid / out_stall status, present, result_coeff
//
// Load, clear, unused codes and range errors: from accept to S_DONE to result.
// Sum query: S_SUM, then S_DONE (one coefficient memory read).
// Product query: S_PROD walks the index pairs i + j = degree inside the
// stores (up to MAX_TERMS), one pair per cycle through the memory read
// ports and the multiply-accumulate pipeline, then S_PWAIT and S_DONE. One item is in work at a time.
// Reset clears presence bits at once; coefficient memories are not cleared.
// A result held by out_stall does not block acceptance of the next beat.

module sparse_polynomial_add_multiply_unit import spam_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               opcode,
  input  logic [DEG_W-1:0]         degree,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ST_W-1:0]          status,
  output logic                     present,
  output logic signed [ACC_W-1:0]  result_coeff
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam int XW = DEG_W + 1;
  localparam logic [XW-1:0] DEPTH    = XW'(MAX_TERMS);
  localparam logic [XW-1:0] TOP_IDX  = XW'(MAX_TERMS - 1);
  localparam logic [XW-1:0] PROD_MAX = XW'(2 * MAX_TERMS - 2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_PROD  = 5'b00100,
    S_PWAIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic signed [COEF_W-1:0] mem_a [MAX_TERMS];
  logic signed [COEF_W-1:0] mem_b [MAX_TERMS];
  logic signed [COEF_W-1:0] rd_a;
  logic signed [COEF_W-1:0] rd_b;
  logic [MAX_TERMS-1:0]     pa;
  logic [MAX_TERMS-1:0]     pb;

  logic [XW-1:0] k;
  logic [XW-1:0] idx;
  logic [XW-1:0] idx_hi;
  logic          sa;
  logic          sb;
  logic          hit1;
  logic          last1;

  logic [ST_W-1:0]         res_status;
  logic                    res_present;
  logic signed [ACC_W-1:0] res_coeff;

  logic                     accept;
  logic [XW-1:0]            deg_x;
  logic [AW-1:0]            deg_idx;
  logic                     in_rng;
  logic [XW-1:0]            i_lo;
  logic [XW-1:0]            i_hi;
  logic [XW-1:0]            j_x;
  logic [AW-1:0]            rd_a_addr;
  logic [AW-1:0]            rd_b_addr;
  logic                     wr_a;
  logic                     wr_b;
  logic signed [COEF_W-1:0] sum_a;
  logic signed [COEF_W-1:0] sum_b;
  logic signed [ACC_W-1:0]  sum_val;

  mac_ctl_t                mac_ctl;
  mac_stat_t               mac_stat;
  logic signed [ACC_W-1:0] mac_acc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign deg_x   = {1'b0, degree};
  assign deg_idx = degree[AW-1:0];
  assign in_rng  = (deg_x < DEPTH);
  assign i_lo    = (deg_x > TOP_IDX) ? (deg_x - TOP_IDX) : '0;
  assign i_hi    = (deg_x > TOP_IDX) ? TOP_IDX : deg_x;
  assign j_x     = k - idx;

  assign rd_a_addr = (state == S_PROD) ? idx[AW-1:0] : deg_idx;
  assign rd_b_addr = (state == S_PROD) ? j_x[AW-1:0] : deg_idx;

  assign wr_a = accept && (opcode == OP_LOAD_A) && in_rng && !pa[deg_idx];
  assign wr_b = accept && (opcode == OP_LOAD_B) && in_rng && !pb[deg_idx];

  assign sum_a   = sa ? rd_a : '0;
  assign sum_b   = sb ? rd_b : '0;
  assign sum_val = ACC_W'(sum_a) + ACC_W'(sum_b);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[deg_idx] <= coefficient;
    end
    rd_a <= mem_a[rd_a_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[deg_idx] <= coefficient;
    end
    rd_b <= mem_b[rd_b_addr];
  end

  assign mac_ctl = '{start: accept, hit: hit1, last: last1};

  spam_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (rd_a),
    .b    (rd_b),
    .stat (mac_stat),
    .acc  (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pa        <= '0;
      pb        <= '0;
      hit1      <= 1'b0;
      last1     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      hit1      <= (state == S_PROD) && pa[idx[AW-1:0]] && pb[j_x[AW-1:0]];
      last1     <= (state == S_PROD) && (idx == idx_hi);
      out_valid <= (state == S_DONE) || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_present <= 1'b0;
            res_coeff   <= '0;
            k           <= deg_x;
            idx         <= i_lo;
            idx_hi      <= i_hi;
            case (opcode)
              OP_LOAD_A: begin
                state <= S_DONE;
                if (!in_rng) begin
                  res_status <= ST_RANGE;
                end else if (pa[deg_idx]) begin
                  res_status <= ST_DUP;
                end else begin
                  res_status  <= ST_OK;
                  pa[deg_idx] <= 1'b1;
                end
              end
              OP_LOAD_B: begin
                state <= S_DONE;
                if (!in_rng) begin
                  res_status <= ST_RANGE;
                end else if (pb[deg_idx]) begin
                  res_status <= ST_DUP;
                end else begin
                  res_status  <= ST_OK;
                  pb[deg_idx] <= 1'b1;
                end
              end
              OP_SUM: begin
                if (!in_rng) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  sa         <= pa[deg_idx];
                  sb         <= pb[deg_idx];
                  state      <= S_SUM;
                end
              end
              OP_PROD: begin
                if (deg_x > PROD_MAX) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_PROD;
                end
              end
              OP_CLEAR: begin
                res_status <= ST_OK;
                state      <= S_DONE;
                pa         <= '0;
                pb         <= '0;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SUM: begin
          res_present <= sa || sb;
          res_coeff   <= sum_val;
          state       <= S_DONE;
        end
        S_PROD: begin
          idx <= idx + 1'b1;
          if (idx == idx_hi) begin
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (mac_stat.done) begin
            res_present <= mac_stat.present;
            res_coeff   <= mac_acc;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status       <= res_status;
            present      <= res_present;
            result_coeff <= res_coeff;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb_sparse_polynomial_add_multiply_unit.sv
`timescale 1ns / 1ps

module tb_sparse_polynomial_add_multiply_unit;
  import spam_pkg::*;

  localparam int RANDOM_ITEMS  = 1450;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int N_ROWS        = 25;

  localparam logic [2:0]       OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]       OP_UNUSED_HI = 3'd7;
  localparam logic [DEG_W-1:0] DEG_TOP      = '1;
  localparam logic [DEG_W-1:0] DEG_LAST     = DEG_W'(MAX_TERMS_DEF - 1);
  localparam logic [DEG_W-1:0] DEG_OVER     = DEG_W'(MAX_TERMS_DEF);
  localparam logic [DEG_W-1:0] DEG_PROD_TOP = DEG_W'(2 * MAX_TERMS_DEF - 2);
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

  typedef struct packed {
    logic [ST_W-1:0]         st;
    logic                    pres;
    logic signed [ACC_W-1:0] val;
  } poly_result_t;

  typedef struct packed {
    logic [2:0]               op;
    logic [DEG_W-1:0]         deg;
    logic signed [COEF_W-1:0] coef;
    logic                     typed;
    poly_result_t             want;
  } stim_row_t;

  localparam poly_result_t RES_OK    = '{st: ST_OK,    pres: 1'b0, val: '0};
  localparam poly_result_t RES_DUP   = '{st: ST_DUP,   pres: 1'b0, val: '0};
  localparam poly_result_t RES_RANGE = '{st: ST_RANGE, pres: 1'b0, val: '0};

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               opcode;
  logic [DEG_W-1:0]         degree;
  logic signed [COEF_W-1:0] coefficient;
  logic                     out_valid;
  logic                     out_stall;
  logic [ST_W-1:0]          status;
  logic                     present;
  logic signed [ACC_W-1:0]  result_coeff;

  logic signed [COEF_W-1:0] poly_a_coef [MAX_TERMS_DEF];
  bit                       poly_a_used [MAX_TERMS_DEF];
  logic signed [COEF_W-1:0] poly_b_coef [MAX_TERMS_DEF];
  bit                       poly_b_used [MAX_TERMS_DEF];

  poly_result_t result_q [$];
  stim_row_t    directed_rows [N_ROWS];

  bit tx_idle;
  bit rx_idle;
  bit long_hold_req;

  int n_work, n_loads, n_sums, n_prods, n_clears, n_unused;
  int n_results, n_present_seen, n_dup_seen, n_range_seen, n_long_holds;
  int n_errors;

  sparse_polynomial_add_multiply_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .degree       (degree),
    .coefficient  (coefficient),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .present      (present),
    .result_coeff (result_coeff)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic poly_result_t predict_term(input logic [2:0] op,
                                                input logic [DEG_W-1:0] deg,
                                                input logic signed [COEF_W-1:0] coef);
    poly_result_t r;
    longint       acc;
    int           j;
    r   = RES_OK;
    acc = 0;
    case (op)
      OP_LOAD_A: begin
        if (deg >= MAX_TERMS_DEF) r.st = ST_RANGE;
        else if (poly_a_used[deg]) r.st = ST_DUP;
        else begin
          poly_a_used[deg] = 1'b1;
          poly_a_coef[deg] = coef;
        end
      end
      OP_LOAD_B: begin
        if (deg >= MAX_TERMS_DEF) r.st = ST_RANGE;
        else if (poly_b_used[deg]) r.st = ST_DUP;
        else begin
          poly_b_used[deg] = 1'b1;
          poly_b_coef[deg] = coef;
        end
      end
      OP_SUM: begin
        if (deg >= MAX_TERMS_DEF) r.st = ST_RANGE;
        else begin
          if (poly_a_used[deg]) begin
            r.pres = 1'b1;
            acc += longint'(poly_a_coef[deg]);
          end
          if (poly_b_used[deg]) begin
            r.pres = 1'b1;
            acc += longint'(poly_b_coef[deg]);
          end
        end
      end
      OP_PROD: begin
        if (deg > 2 * MAX_TERMS_DEF - 2) r.st = ST_RANGE;
        else begin
          for (int i = 0; i < MAX_TERMS_DEF && i <= int'(deg); i++) begin
            j = int'(deg) - i;
            if (j < MAX_TERMS_DEF && poly_a_used[i] && poly_b_used[j]) begin
              r.pres = 1'b1;
              acc += longint'(poly_a_coef[i]) * longint'(poly_b_coef[j]);
            end
          end
        end
      end
      OP_CLEAR: begin
        foreach (poly_a_used[i]) begin
          poly_a_used[i] = 1'b0;
          poly_b_used[i] = 1'b0;
          poly_a_coef[i] = '0;
          poly_b_coef[i] = '0;
        end
      end
      default: ;
    endcase
    r.val = acc[ACC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [DEG_W-1:0] deg,
                           input logic signed [COEF_W-1:0] coef,
                           input logic typed, input poly_result_t typed_want);
    int           gap;
    poly_result_t want;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    opcode      = op;
    degree      = deg;
    coefficient = coef;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_term(op, deg, coef);
    if (typed) want = typed_want;
    result_q.push_back(want);
    case (op)
      OP_LOAD_A, OP_LOAD_B: n_loads++;
      OP_SUM:               n_sums++;
      OP_PROD:              n_prods++;
      OP_CLEAR:             n_clears++;
      default:              n_unused++;
    endcase
    if (op <= OP_CLEAR) n_work++;
    @(negedge clk);
  endtask

  task automatic send_query();
    if ($urandom_range(0, 2) == 0)
      send_item(OP_SUM, ($urandom_range(0, 7) == 0) ? DEG_W'($urandom_range(MAX_TERMS_DEF, 63))
                                                     : DEG_W'($urandom_range(0, MAX_TERMS_DEF - 1)),
                rand_coef(), 1'b0, RES_OK);
    else
      send_item(OP_PROD, ($urandom_range(0, 15) == 0) ? DEG_TOP
                                                       : DEG_W'($urandom_range(0, DEG_PROD_TOP)),
                rand_coef(), 1'b0, RES_OK);
  endtask

  always @(posedge clk) begin : check_results
    poly_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (present) n_present_seen++;
      if (status == ST_DUP) n_dup_seen++;
      if (status == ST_RANGE) n_range_seen++;
      if (result_q.size() == 0) begin
        if (n_errors < 10)
          $display("unexpected result beat: status %0d present %0b coeff %0d",
                   status, present, result_coeff);
        n_errors++;
      end else begin
        want = result_q.pop_front();
        if (status !== want.st || present !== want.pres || result_coeff !== want.val) begin
          if (n_errors < 10)
            $display("result %0d: expected status %0d present %0b coeff %0d, got %0d %0b %0d",
                     n_results, want.st, want.pres, want.val, status, present, result_coeff);
          n_errors++;
        end
      end
    end
  end

  initial begin : receiver
    int stall_n;
    out_stall = 1'b0;
    rx_idle   = 1'b1;
    @(negedge clk);
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      stall_n = rx_idle ? $urandom_range(0, 19) : 0;
      if (long_hold_req) begin
        stall_n += LONG_HOLD;
        long_hold_req = 1'b0;
        n_long_holds++;
      end
      if (stall_n != 0) begin
        out_stall = 1'b1;
        repeat (stall_n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                       seq_idx;
    int                       n_terms;
    int                       n_queries;
    int                       full_mode;
    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] cb;

    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_LOAD_A;
    degree        = '0;
    coefficient   = '0;
    tx_idle       = 1'b1;
    long_hold_req = 1'b0;

    directed_rows = '{
      '{OP_SUM,       6'd0,         16'sd0,   1'b1, RES_OK},
      '{OP_PROD,      6'd0,         16'sd0,   1'b1, RES_OK},
      '{OP_LOAD_A,    6'd0,         COEF_MAX, 1'b1, RES_OK},
      '{OP_LOAD_A,    6'd0,         16'sd5,   1'b1, RES_DUP},
      '{OP_LOAD_A,    DEG_LAST,     COEF_MIN, 1'b1, RES_OK},
      '{OP_LOAD_A,    DEG_OVER,     16'sd1,   1'b1, RES_RANGE},
      '{OP_LOAD_B,    DEG_TOP,      -16'sd1,  1'b1, RES_RANGE},
      '{OP_LOAD_B,    6'd0,         COEF_MIN, 1'b1, RES_OK},
      '{OP_LOAD_B,    DEG_LAST,     COEF_MIN, 1'b1, RES_OK},
      '{OP_LOAD_B,    6'd7,         16'sd0,   1'b1, RES_OK},
      '{OP_LOAD_B,    6'd7,         16'sd1,   1'b1, RES_DUP},
      '{OP_SUM,       6'd0,         16'sd0,   1'b0, RES_OK},
      '{OP_SUM,       6'd7,         16'sd0,   1'b0, RES_OK},
      '{OP_SUM,       6'd3,         16'sd0,   1'b1, RES_OK},
      '{OP_SUM,       DEG_OVER,     16'sd0,   1'b1, RES_RANGE},
      '{OP_SUM,       DEG_TOP,      COEF_MIN, 1'b1, RES_RANGE},
      '{OP_PROD,      6'd0,         16'sd0,   1'b0, RES_OK},
      '{OP_PROD,      DEG_PROD_TOP, 16'sd0,   1'b0, RES_OK},
      '{OP_PROD,      DEG_LAST,     16'sd0,   1'b0, RES_OK},
      '{OP_PROD,      DEG_TOP,      16'sd0,   1'b1, RES_RANGE},
      '{OP_UNUSED_LO, 6'd12,        -16'sd1,  1'b1, RES_OK},
      '{OP_UNUSED_HI, DEG_TOP,      COEF_MAX, 1'b1, RES_OK},
      '{OP_CLEAR,     6'd0,         16'sd0,   1'b1, RES_OK},
      '{OP_SUM,       6'd0,         16'sd0,   1'b1, RES_OK},
      '{OP_PROD,      DEG_PROD_TOP, 16'sd0,   1'b1, RES_OK}
    };

    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r])
      send_item(directed_rows[r].op, directed_rows[r].deg, directed_rows[r].coef,
                directed_rows[r].typed, directed_rows[r].want);

    n_work  = 0;
    seq_idx = 0;
    while (n_work < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      if (seq_idx % 25 == 10) begin
        long_hold_req = 1'b1;
        tx_idle       = 1'b0;
      end
      if (seq_idx % 25 == 20) begin
        in_valid = 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end

      if (seq_idx % 30 == 5) begin
        full_mode = (seq_idx / 30) % 3;
        send_item(OP_CLEAR, DEG_W'($urandom), COEF_W'($urandom), 1'b0, RES_OK);
        for (int i = 0; i < MAX_TERMS_DEF; i++) begin
          case (full_mode)
            0: begin
              ca = COEF_MIN;
              cb = COEF_MIN;
            end
            1: begin
              ca = COEF_MIN;
              cb = COEF_MAX;
            end
            default: begin
              ca = rand_coef();
              cb = rand_coef();
            end
          endcase
          send_item(OP_LOAD_A, DEG_W'(i), ca, 1'b0, RES_OK);
          send_item(OP_LOAD_B, DEG_W'(i), cb, 1'b0, RES_OK);
        end
        send_item(OP_PROD, DEG_LAST, '0, 1'b0, RES_OK);
        send_item(OP_PROD, DEG_PROD_TOP, '0, 1'b0, RES_OK);
        send_item(OP_PROD, 6'd0, '0, 1'b0, RES_OK);
        repeat (8) send_query();
      end else if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0)
          send_item(OP_CLEAR, DEG_W'($urandom), COEF_W'($urandom), 1'b0, RES_OK);
        n_terms = $urandom_range(2, 24);
        repeat (n_terms)
          send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                    ($urandom_range(0, 9) == 0) ? DEG_W'($urandom_range(MAX_TERMS_DEF, 63))
                                                : DEG_W'($urandom_range(0, MAX_TERMS_DEF - 1)),
                    rand_coef(), 1'b0, RES_OK);
        n_queries = $urandom_range(2, 10);
        repeat (n_queries) send_query();
      end else begin
        n_terms = $urandom_range(1, 6);
        repeat (n_terms)
          send_item(3'($urandom_range(0, OP_UNUSED_HI)), DEG_W'($urandom), COEF_W'($urandom),
                    1'b0, RES_OK);
      end
      seq_idx++;
    end

    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d sum and %0d product queries, %0d clears, %0d unused codes",
             n_loads, n_sums, n_prods, n_clears, n_unused);
    $display("checked %0d results: %0d present, %0d duplicate, %0d out of range; %0d long holds",
             n_results, n_present_seen, n_dup_seen, n_range_seen, n_long_holds);
    if (n_errors == 0)
      $display("sparse_polynomial_add_multiply_unit: match");
    else
      $display("sparse_polynomial_add_multiply_unit: mismatch");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", result_q.size());
    $display("sparse_polynomial_add_multiply_unit: mismatch");
    $finish;
  end

endmodule
